@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // Bitmap capacity in blocks and the geometry of the bitmap memory.
  localparam int unsigned MAX_BLOCKS = 65536;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W    = $clog2(WORD_COUNT);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths of the command and result words.
  localparam int unsigned SECTOR_W   = 32;
  localparam int unsigned WIDX_W     = 11;
  localparam int unsigned BCNT_W     = 17;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_FIRST_SECTOR = 1'b0,
    REG_BLOCK_COUNT  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

endpackage : bba_pkg

`default_nettype wire

@@ design/bitmap_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit allocator over a used/free bitmap held in one synchronous memory.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                     Direction  Flow
//  -------   -----------------------------------------   ---------  ---------------
//  command   start, busy, opcode/sector/word_index/...   in         start & !busy
//  result    done_o, status/allocated_sector/changed...  out        one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata, ...   in/out     APB, no wait
//
// A load, a no-op and a rejected free show their result in the cycle after the
// command word is accepted. A valid free reads its bitmap word and writes it
// back in state S_FREE, and its result follows that write-back. An allocate
// scans the bitmap memory one word per cycle through its single read port,
// k words in all (0 when the block count is zero, else 1 up to WORD_COUNT,
// 2048 by default), so the memory read port sets the rate.
// After reset the block sweeps all WORD_COUNT words of the memory to zero, one
// word a cycle, with busy high; configuration writes are taken meanwhile.
// The result word cannot be stalled: it is valid only while done_o is high.
//
`default_nettype none

module bitmap_block_allocator_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Command channel
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        opcode_i,
  input  wire  [bba_pkg::SECTOR_W-1:0]      sector_i,
  input  wire  [bba_pkg::WIDX_W-1:0]        word_index_i,
  input  wire  [bba_pkg::WORD_BITS-1:0]     word_value_i,
  // Result channel
  output logic                              done_o,
  output logic [bba_pkg::STATUS_W-1:0]      status_o,
  output logic [bba_pkg::SECTOR_W-1:0]      allocated_sector_o,
  output logic                              changed_o,
  output logic [bba_pkg::WIDX_W-1:0]        changed_word_o,
  // Configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [bba_pkg::APB_AW-1:0]        paddr,
  input  wire  [bba_pkg::APB_DW-1:0]        pwdata,
  output logic [bba_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);
  import bba_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Register i sits at byte address 4*i, so bit 2 of
  // the address picks the register and the byte offset bits are ignored.
  // ---------------------------------------------------------------------------
  logic [SECTOR_W-1:0] first_sector_q;
  logic [BCNT_W-1:0]   block_count_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sector_q <= '0;
      block_count_q  <= BCNT_W'(MAX_BLOCKS);
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_FIRST_SECTOR: first_sector_q <= pwdata[SECTOR_W-1:0];
        REG_BLOCK_COUNT:  block_count_q  <= pwdata[BCNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_FIRST_SECTOR: prdata = APB_DW'(first_sector_q);
      REG_BLOCK_COUNT:  prdata = APB_DW'(block_count_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective block count, saturated at the bitmap capacity, and the geometry
  // of the last word that holds managed blocks.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]     eff_count;
  logic [CNT_W-1:0]     last_block;
  logic [WADDR_W-1:0]   last_word;
  logic [BIT_W:0]       last_fill;   // managed bits in the last word, 1 to 32
  logic [WORD_BITS-1:0] last_mask;

  always_comb begin
    if (32'(block_count_q) > 32'(MAX_BLOCKS)) begin
      eff_count = CNT_W'(MAX_BLOCKS);
    end else begin
      eff_count = CNT_W'(block_count_q);
    end
    last_block = eff_count - CNT_W'(1);
    last_word  = WADDR_W'(last_block >> BIT_W);
    last_fill  = {1'b0, last_block[BIT_W-1:0]} + (BIT_W+1)'(1);
    last_mask  = ~({WORD_BITS{1'b1}} << last_fill);
  end

  // ---------------------------------------------------------------------------
  // Bitmap memory: one write port and one registered read port.
  // ---------------------------------------------------------------------------
  logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WADDR_W-1:0]   mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= bitmap_mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [WADDR_W-1:0]   addr_q, addr_d;     // clear pointer, scan word, free word
  logic [BIT_W-1:0]     bit_q, bit_d;       // bit to release on a free
  logic                 done_q, done_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [SECTOR_W-1:0]  sector_q, sector_d;
  logic                 changed_q, changed_d;
  logic [WIDX_W-1:0]    cword_q, cword_d;

  // Free request decode, done straight off the command word.
  logic [SECTOR_W:0]    free_diff;
  logic                 free_below;
  logic                 free_beyond;
  logic [SECTOR_W-1:0]  free_index;

  assign free_diff   = {1'b0, sector_i} - {1'b0, first_sector_q};
  assign free_below  = free_diff[SECTOR_W];
  assign free_index  = free_diff[SECTOR_W-1:0];
  assign free_beyond = free_index >= SECTOR_W'(eff_count);

  // First free bit of the word under scan, restricted to managed blocks.
  logic [WORD_BITS-1:0] scan_free;
  logic                 scan_hit;
  logic [BIT_W-1:0]     scan_bit;

  always_comb begin
    scan_free = ~mem_rdata_q;
    if (addr_q == last_word) begin
      scan_free = scan_free & last_mask;
    end
    scan_hit = |scan_free;
    scan_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (scan_free[b]) begin
        scan_bit = BIT_W'(b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      addr_q    <= '0;
      done_q    <= 1'b0;
      bit_q     <= '0;
      status_q  <= '0;
      sector_q  <= '0;
      changed_q <= 1'b0;
      cword_q   <= '0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      done_q    <= done_d;
      bit_q     <= bit_d;
      status_q  <= status_d;
      sector_q  <= sector_d;
      changed_q <= changed_d;
      cword_q   <= cword_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    bit_d     = bit_q;
    done_d    = 1'b0;
    status_d  = status_q;
    sector_d  = sector_q;
    changed_d = changed_q;
    cword_d   = cword_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_raddr = addr_q + WADDR_W'(1);

    case (state_q)
      // Sweep the bitmap to all free after reset.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        addr_d    = addr_q + WADDR_W'(1);
        if (addr_q == WADDR_W'(WORD_COUNT - 1)) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          // Every command finishes with a result; fields default to zero.
          status_d  = ST_OK;
          sector_d  = '0;
          changed_d = 1'b0;
          cword_d   = '0;
          case (opcode_e'(opcode_i))
            OP_ALLOC: begin
              if (eff_count == '0) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else begin
                mem_raddr = '0;
                addr_d    = '0;
                state_d   = S_SCAN;
              end
            end
            OP_FREE: begin
              if (free_below || free_beyond) begin
                status_d = ST_RANGE;
                done_d   = 1'b1;
              end else begin
                mem_raddr = free_index[WADDR_W+BIT_W-1:BIT_W];
                addr_d    = free_index[WADDR_W+BIT_W-1:BIT_W];
                bit_d     = free_index[BIT_W-1:0];
                state_d   = S_FREE;
              end
            end
            OP_LOAD: begin
              // Contents come from disk, so nothing is reported as changed.
              if (32'(word_index_i) < 32'(WORD_COUNT)) begin
                mem_we    = 1'b1;
                mem_waddr = WADDR_W'(word_index_i);
                mem_wdata = word_value_i;
              end else begin
                status_d = ST_RANGE;
              end
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // The read data holds word addr_q; the read of the next word is in flight.
      S_SCAN: begin
        if (scan_hit) begin
          mem_we    = 1'b1;
          mem_waddr = addr_q;
          mem_wdata = mem_rdata_q | (WORD_BITS'(1) << scan_bit);
          status_d  = ST_OK;
          sector_d  = first_sector_q + SECTOR_W'({addr_q, scan_bit});
          changed_d = 1'b1;
          cword_d   = WIDX_W'(addr_q);
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else if (addr_q == last_word) begin
          status_d = ST_FULL;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          addr_d = addr_q + WADDR_W'(1);
        end
      end

      // Clear the bit; the word is reported even when the bit was already free.
      S_FREE: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = mem_rdata_q & ~(WORD_BITS'(1) << bit_q);
        changed_d = 1'b1;
        cword_d   = WIDX_W'(addr_q);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy               = (state_q != S_IDLE);
  assign done_o             = done_q;
  assign status_o           = status_q;
  assign allocated_sector_o = sector_q;
  assign changed_o          = changed_q;
  assign changed_word_o     = cword_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= last_word))
    else $error("allocate scan ran past the last managed word");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || state_q == S_SCAN || state_q == S_FREE))
    else $error("accepted command neither finished nor started its work");

  a_changed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && changed_o) |-> (status_o == ST_OK))
    else $error("changed word reported with an error status");

  a_full_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (!changed_o && allocated_sector_o == '0))
    else $error("full allocate reported a grant or a change");

  a_free_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE) |=> (state_q == S_IDLE && done_o))
    else $error("free did not finish in its write-back cycle");

endmodule : bitmap_block_allocator_core

`default_nettype wire
